FILE: rtl/i2c_bitbang_write_sequencer_core_defines.svh
// ---------------------------------------------------------------------------
// I2C bit-bang write sequencer: assertion macros
// Concurrent check macros shared by the sequencer modules.
// ---------------------------------------------------------------------------
`ifndef I2C_BITBANG_WRITE_SEQUENCER_CORE_DEFINES_SVH
`define I2C_BITBANG_WRITE_SEQUENCER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define I2CBB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2cbb check failed");
`define I2CBB_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2cbb check failed");
`else
`define I2CBB_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define I2CBB_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/i2cbb_pkg.sv
// ---------------------------------------------------------------------------
// I2C bit-bang write sequencer package
// Port bit assignments, command codes and the queued job descriptor.
// ---------------------------------------------------------------------------
package i2cbb_pkg;

  localparam logic [7:0] BUS_EN    = 8'h04;
  localparam logic [7:0] LINE_SCL  = 8'h10;
  localparam logic [7:0] LINE_SDA  = 8'h80;
  localparam logic [7:0] KEEP_MASK = 8'h4b;
  localparam logic [7:0] STOP_MASK = 8'h8b;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_NONE  = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    JOB_START = 2'd0,
    JOB_BYTE  = 2'd1,
    JOB_STOP  = 2'd2,
    JOB_FAIL  = 2'd3
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] base;
    logic [7:0] data;
    logic       status_ok;
  } job_t;

endpackage

FILE: rtl/i2c_bitbang_write_sequencer_core.sv
// ---------------------------------------------------------------------------
// I2C bit-bang write sequencer core
// Turns start, byte and stop commands into port write sequences.
// ---------------------------------------------------------------------------
//  channel | dir | tdata                               | tuser       | tlast
//  s_*     | in  | base_value, data_byte, ack_ok       | command     | -
//  m_*     | out | port_value, status_ok               | write_valid | last
//
//  Start and stop give 3 results, a byte 28 (1 after a failed ack), one per
//  cycle from the sequencer while m_tready does not stall the output.
//  Jobs queue back to back; the input stalls only when the job queue is full.
//  Command code 3 is taken and dropped. Reset is synchronous.
// ---------------------------------------------------------------------------
module i2c_bitbang_write_sequencer_core #(
  parameter int QUEUE_DEPTH = i2cbb_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // base_value[7:0], data_byte[15:8], ack_ok[16]
  input  logic [1:0]  s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // port_value[7:0], status_ok[8]
  output logic        m_tuser,   // write_valid
  output logic        m_tlast
);

  i2cbb_pkg::job_t push_job;
  i2cbb_pkg::job_t head_job;
  logic            push;
  logic            push_ready;
  logic            head_valid;
  logic            head_pop;

  i2cbb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_ready  (push_ready),
    .q_push   (push),
    .q_job    (push_job)
  );

  i2cbb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push),
    .in_ready  (push_ready),
    .in_job    (push_job),
    .out_valid (head_valid),
    .out_ready (head_pop),
    .out_job   (head_job)
  );

  i2cbb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (head_valid),
    .q_pop    (head_pop),
    .q_job    (head_job),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: rtl/i2cbb_front.sv
// ---------------------------------------------------------------------------
// I2C bit-bang front end
// Accepts commands, tracks port base and ack failure, issues job descriptors.
// ---------------------------------------------------------------------------
module i2cbb_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [23:0]     s_tdata,   // base_value[7:0], data_byte[15:8], ack_ok[16]
  input  logic [1:0]      s_tuser,   // command[1:0]
  input  logic            q_ready,
  output logic            q_push,
  output i2cbb_pkg::job_t q_job
);

  logic [7:0] port_base;
  logic [7:0] port_base_next;
  logic       ack_failed;
  logic       ack_failed_next;
  logic       accept;
  logic       issue;
  logic [7:0] base_value;
  logic [7:0] data_byte;
  logic       ack_ok;

  assign s_tready   = q_ready;
  assign accept     = s_tvalid && s_tready;
  assign base_value = s_tdata[7:0];
  assign data_byte  = s_tdata[15:8];
  assign ack_ok     = s_tdata[16];
  assign q_push     = accept && issue;

  always_comb begin
    port_base_next  = port_base;
    ack_failed_next = ack_failed;
    issue           = 1'b1;
    q_job.kind      = i2cbb_pkg::JOB_STOP;
    q_job.base      = port_base;
    q_job.data      = data_byte;
    q_job.status_ok = !ack_failed;
    unique case (i2cbb_pkg::command_t'(s_tuser))
      i2cbb_pkg::CMD_START: begin
        port_base_next  = (base_value & i2cbb_pkg::KEEP_MASK) | i2cbb_pkg::BUS_EN;
        ack_failed_next = 1'b0;
        q_job.kind      = i2cbb_pkg::JOB_START;
        q_job.base      = port_base_next;
        q_job.status_ok = 1'b1;
      end
      i2cbb_pkg::CMD_BYTE: begin
        if (ack_failed) begin
          q_job.kind      = i2cbb_pkg::JOB_FAIL;
          q_job.status_ok = 1'b0;
        end else begin
          ack_failed_next = !ack_ok;
          q_job.kind      = i2cbb_pkg::JOB_BYTE;
          q_job.status_ok = ack_ok;
        end
      end
      i2cbb_pkg::CMD_STOP: begin
        q_job.kind = i2cbb_pkg::JOB_STOP;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_base  <= '0;
      ack_failed <= 1'b0;
    end else if (accept) begin
      port_base  <= port_base_next;
      ack_failed <= ack_failed_next;
    end
  end

endmodule

FILE: rtl/i2cbb_queue.sv
// ---------------------------------------------------------------------------
// I2C bit-bang job queue
// Small FIFO of job descriptors between front end and sequencer.
// ---------------------------------------------------------------------------
`include "i2c_bitbang_write_sequencer_core_defines.svh"

module i2cbb_queue #(
  parameter int DEPTH = i2cbb_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  i2cbb_pkg::job_t in_job,
  output logic            out_valid,
  input  logic            out_ready,
  output i2cbb_pkg::job_t out_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  i2cbb_pkg::job_t entries [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_job   = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= in_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `I2CBB_ASSERT_IMP(a_empty_ptrs_meet, clk, rst, count == '0, wptr == rptr)
  `I2CBB_ASSERT_NXT(a_push_shows_data, clk, rst, push && !pop, out_valid)

endmodule

FILE: rtl/i2cbb_back.sv
// ---------------------------------------------------------------------------
// I2C bit-bang sequencer
// Expands queued jobs into port writes, one result per cycle unless m_tready stalls the output.
// ---------------------------------------------------------------------------
`include "i2c_bitbang_write_sequencer_core_defines.svh"

module i2cbb_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_pop,
  input  i2cbb_pkg::job_t q_job,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [15:0]     m_tdata,   // port_value[7:0], status_ok[8]
  output logic            m_tuser,   // write_valid
  output logic            m_tlast
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_START = 6'b000010,
    ST_CLEAR = 6'b000100,
    ST_SHIFT = 6'b001000,
    ST_STOP  = 6'b010000,
    ST_FAIL  = 6'b100000
  } seq_state_t;

  seq_state_t      state;
  seq_state_t      state_next;
  i2cbb_pkg::job_t cur;
  logic [1:0]      phase;
  logic [1:0]      phase_next;
  logic [3:0]      bitcnt;
  logic [3:0]      bitcnt_next;
  logic [8:0]      sh;
  logic [8:0]      sh_next;
  logic            adv;
  logic            is_last;
  logic [7:0]      pv;
  logic            wv;
  logic [7:0]      bit_val;

  assign adv     = (state != ST_IDLE) && (!m_tvalid || m_tready);
  assign q_pop   = q_valid && ((state == ST_IDLE) || (adv && is_last));
  assign bit_val = cur.base | (sh[8] ? i2cbb_pkg::LINE_SDA : 8'h00);

  always_comb begin
    pv      = cur.base;
    wv      = 1'b1;
    is_last = 1'b0;
    unique case (state)
      ST_START: begin
        is_last = (phase == 2'd2);
        case (phase)
          2'd0:    pv = (cur.base & ~i2cbb_pkg::BUS_EN) | i2cbb_pkg::LINE_SCL
                        | i2cbb_pkg::LINE_SDA;
          2'd1:    pv = cur.base | i2cbb_pkg::LINE_SCL | i2cbb_pkg::LINE_SDA;
          default: pv = cur.base | i2cbb_pkg::LINE_SCL;
        endcase
      end
      ST_CLEAR: begin
        pv = cur.base;
      end
      ST_SHIFT: begin
        is_last = (phase == 2'd2) && (bitcnt == 4'd8);
        pv      = (phase == 2'd1) ? (bit_val | i2cbb_pkg::LINE_SCL) : bit_val;
      end
      ST_STOP: begin
        is_last = (phase == 2'd2);
        case (phase)
          2'd0:    pv = cur.base | i2cbb_pkg::LINE_SCL;
          2'd1:    pv = cur.base | i2cbb_pkg::LINE_SCL | i2cbb_pkg::LINE_SDA;
          default: pv = (cur.base & i2cbb_pkg::STOP_MASK) | i2cbb_pkg::LINE_SCL
                        | i2cbb_pkg::LINE_SDA;
        endcase
      end
      ST_FAIL: begin
        pv      = 8'h00;
        wv      = 1'b0;
        is_last = 1'b1;
      end
      default: begin
        pv      = cur.base;
        wv      = 1'b0;
        is_last = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next  = state;
    phase_next  = phase;
    bitcnt_next = bitcnt;
    sh_next     = sh;
    if (adv) begin
      phase_next = (phase == 2'd2) ? 2'd0 : phase + 1'b1;
      if (state == ST_CLEAR) begin
        state_next = ST_SHIFT;
        phase_next = 2'd0;
      end else if (state == ST_SHIFT && phase == 2'd2) begin
        sh_next     = {sh[7:0], 1'b0};
        bitcnt_next = bitcnt + 1'b1;
      end
      if (is_last) begin
        state_next = ST_IDLE;
      end
    end
    if (q_pop) begin
      phase_next  = 2'd0;
      bitcnt_next = '0;
      sh_next     = {q_job.data, 1'b1};
      unique case (q_job.kind)
        i2cbb_pkg::JOB_START: state_next = ST_START;
        i2cbb_pkg::JOB_BYTE:  state_next = ST_CLEAR;
        i2cbb_pkg::JOB_STOP:  state_next = ST_STOP;
        default:              state_next = ST_FAIL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
    end
    sh <= sh_next;
    if (adv) begin
      m_tdata <= {7'b0, cur.status_ok, pv};
      m_tuser <= wv;
      m_tlast <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= '0;
      bitcnt   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      phase  <= phase_next;
      bitcnt <= bitcnt_next;
      if (adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `I2CBB_ASSERT_IMP(a_bitcnt_range, clk, rst, state == ST_SHIFT, bitcnt <= 4'd8)
  `I2CBB_ASSERT_IMP(a_fail_result, clk, rst, m_tvalid && !m_tuser, m_tlast && !m_tdata[8])

endmodule
